// File: hdl/rmsa_pkg.sv
// Shared widths, status codes and sizing for the running mean / std-dev accumulator.
// No dependencies; every other file in hdl/ uses this package by scoped names.
`default_nettype none

package rmsa_pkg;

  // sample and count formats
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  // port widths of the word fields
  localparam int VAL_W  = 24;
  localparam int CNT_W  = 16;
  localparam int STAT_W = 2;

  // exact accumulator widths
  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_W = 2 * SUM_W;

  // serial multiplier: multiplicand sized for the sum of squares, multiplier for the |sum|
  localparam int MA_W    = SQ_W;
  localparam int MB_W    = SUM_W;
  localparam int MSTEP_W = $clog2(MB_W + 1);

  // serial divider: divisor sized for n*(n-1)
  localparam int DIV_W   = 2 * COUNT_BITS;
  localparam int DSTEP_W = $clog2(PROD_W + 1);

  // square root: variance is below 2^(2*SAMPLE_BITS)
  localparam int VAR_W   = 2 * SAMPLE_BITS;
  localparam int ROOT_W  = SAMPLE_BITS;
  localparam int RSTEP_W = $clog2(ROOT_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: hdl/running_mean_stddev_accumulator_top.sv
// Running mean and sample standard deviation accumulator, top level with sequencer.
// Depends on rmsa_pkg, rmsa_mul, rmsa_div and rmsa_sqrt.
//
// Each input word either clears the statistics or adds one signed sample; every word
// returns one result word with the count, the mean truncated toward zero, the sample
// standard deviation floor(sqrt((n*Q - S*S) / (n*(n-1)))) and the last sample, all from
// exact integer sums. A clear goes straight to the result word and the first sample after a
// clear needs only the sample square. Any other sample goes through the square, n*Q, S*S,
// n*(n-1), the variance divide and the square root; a sample rejected because the count
// is full skips the square. The time is set by one shared bit-serial multiplier (sample
// square, n*Q, S*S, n*(n-1)), then a one-bit-per-cycle divider over the full
// 2*(SAMPLE_BITS+COUNT_BITS) bit difference and a two-bit-per-cycle square root. The mean
// divide runs on its own divider alongside. One word is in work at a time; a finished
// result sits in the output register while the next word is accepted.
`default_nettype none

module running_mean_stddev_accumulator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rmsa_pkg::VAL_W-1:0]  in_sample_value,
  input  logic                               in_clear_request,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rmsa_pkg::CNT_W-1:0]         out_sample_count,
  output logic signed [rmsa_pkg::VAL_W-1:0]  out_mean_value,
  output logic [rmsa_pkg::VAL_W-1:0]         out_std_deviation,
  output logic signed [rmsa_pkg::VAL_W-1:0]  out_last_value,
  output logic [rmsa_pkg::STAT_W-1:0]        out_status_code
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQR   = 9'b000000010,
    S_STATS = 9'b000000100,
    S_NQ    = 9'b000001000,
    S_SS    = 9'b000010000,
    S_NN    = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_SQRT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } fsm_t;

  fsm_t state_r, state_nxt;

  // architectural state
  logic [rmsa_pkg::COUNT_BITS-1:0]          count_r;
  logic signed [rmsa_pkg::SUM_W-1:0]        sum_r;
  logic [rmsa_pkg::SQ_W-1:0]                sq_r;
  logic signed [rmsa_pkg::SAMPLE_BITS-1:0]  last_r;

  // work registers
  logic signed [rmsa_pkg::SAMPLE_BITS-1:0]  v_r;
  rmsa_pkg::status_t                        status_r;
  logic [rmsa_pkg::PROD_W-1:0]              nq_r;
  logic [rmsa_pkg::PROD_W-1:0]              diff_r;
  logic signed [rmsa_pkg::SAMPLE_BITS-1:0]  mean_r;
  logic [rmsa_pkg::ROOT_W-1:0]              sd_r;

  // output word
  logic                                     out_valid_r;
  logic [rmsa_pkg::CNT_W-1:0]               out_sample_count_r;
  logic signed [rmsa_pkg::VAL_W-1:0]        out_mean_value_r;
  logic [rmsa_pkg::VAL_W-1:0]               out_std_deviation_r;
  logic signed [rmsa_pkg::VAL_W-1:0]        out_last_value_r;
  logic [rmsa_pkg::STAT_W-1:0]              out_status_code_r;

  logic                                     accept;
  logic                                     out_free;
  logic signed [rmsa_pkg::SAMPLE_BITS-1:0]  v_in;
  logic [rmsa_pkg::SAMPLE_BITS-1:0]         v_abs;
  logic [rmsa_pkg::SUM_W-1:0]               s_abs;
  logic [rmsa_pkg::SAMPLE_BITS-1:0]         mean_mag;

  // unit hookups
  logic                                     mul_start;
  logic [rmsa_pkg::MA_W-1:0]                mul_a;
  logic [rmsa_pkg::MB_W-1:0]                mul_b;
  logic [rmsa_pkg::MSTEP_W-1:0]             mul_steps;
  logic                                     mul_done;
  logic [rmsa_pkg::PROD_W-1:0]              mul_prod;
  logic                                     mean_start;
  logic                                     mean_done;
  logic [rmsa_pkg::PROD_W-1:0]              mean_quot;
  logic                                     var_start;
  logic                                     var_done;
  logic [rmsa_pkg::PROD_W-1:0]              var_quot;
  logic                                     sqrt_start;
  logic                                     sqrt_done;
  logic [rmsa_pkg::ROOT_W-1:0]              sqrt_root;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign v_in     = in_sample_value[rmsa_pkg::SAMPLE_BITS-1:0];
  assign v_abs    = v_in[rmsa_pkg::SAMPLE_BITS-1] ? rmsa_pkg::SAMPLE_BITS'(-v_in)
                                                 : rmsa_pkg::SAMPLE_BITS'(v_in);
  assign s_abs    = sum_r[rmsa_pkg::SUM_W-1] ? rmsa_pkg::SUM_W'(-sum_r)
                                            : rmsa_pkg::SUM_W'(sum_r);
  assign mean_mag = mean_quot[rmsa_pkg::SAMPLE_BITS-1:0];

  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_steps  = '0;
    mean_start = 1'b0;
    var_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_clear_request) begin
            state_nxt = S_FIN;
          end else if (count_r == rmsa_pkg::COUNT_FULL) begin
            state_nxt = S_STATS;
          end else begin
            mul_start = 1'b1;
            mul_a     = rmsa_pkg::MA_W'(v_abs);
            mul_b     = rmsa_pkg::MB_W'(v_abs) << (rmsa_pkg::MB_W - rmsa_pkg::SAMPLE_BITS);
            mul_steps = rmsa_pkg::MSTEP_W'(rmsa_pkg::SAMPLE_BITS);
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_done) begin
          state_nxt = S_STATS;
        end
      end
      S_STATS: begin
        if (count_r == rmsa_pkg::COUNT_BITS'(1)) begin
          state_nxt = S_FIN;
        end else begin
          // n*Q on the multiplier, S/n on the mean divider
          mul_start  = 1'b1;
          mul_a      = rmsa_pkg::MA_W'(sq_r);
          mul_b      = rmsa_pkg::MB_W'(count_r) << (rmsa_pkg::MB_W - rmsa_pkg::COUNT_BITS);
          mul_steps  = rmsa_pkg::MSTEP_W'(rmsa_pkg::COUNT_BITS);
          mean_start = 1'b1;
          state_nxt  = S_NQ;
        end
      end
      S_NQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = rmsa_pkg::MA_W'(s_abs);
          mul_b     = s_abs;
          mul_steps = rmsa_pkg::MSTEP_W'(rmsa_pkg::SUM_W);
          state_nxt = S_SS;
        end
      end
      S_SS: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = rmsa_pkg::MA_W'(count_r);
          mul_b     = rmsa_pkg::MB_W'(count_r - 1'b1)
                      << (rmsa_pkg::MB_W - rmsa_pkg::COUNT_BITS);
          mul_steps = rmsa_pkg::MSTEP_W'(rmsa_pkg::COUNT_BITS);
          state_nxt = S_NN;
        end
      end
      S_NN: begin
        if (mul_done) begin
          var_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (var_done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  rmsa_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .steps  (mul_steps),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  rmsa_div u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mean_start),
    .dividend (rmsa_pkg::PROD_W'(s_abs) << (rmsa_pkg::PROD_W - rmsa_pkg::SUM_W)),
    .divisor  (rmsa_pkg::DIV_W'(count_r)),
    .steps    (rmsa_pkg::DSTEP_W'(rmsa_pkg::SUM_W)),
    .done     (mean_done),
    .quot     (mean_quot)
  );

  rmsa_div u_var_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (var_start),
    .dividend (diff_r),
    .divisor  (mul_prod[rmsa_pkg::DIV_W-1:0]),
    .steps    (rmsa_pkg::DSTEP_W'(rmsa_pkg::PROD_W)),
    .done     (var_done),
    .quot     (var_quot)
  );

  rmsa_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (var_quot[rmsa_pkg::VAR_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_clear_request) begin
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
        last_r  <= '0;
      end
      if (state_r == S_SQR && mul_done) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + rmsa_pkg::SUM_W'(v_r);
        sq_r    <= sq_r + rmsa_pkg::SQ_W'(mul_prod);
        last_r  <= v_r;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r <= v_in;
      if (in_clear_request) begin
        status_r <= rmsa_pkg::ST_EMPTY;
        mean_r   <= '0;
        sd_r     <= '0;
      end else if (count_r == rmsa_pkg::COUNT_FULL) begin
        status_r <= rmsa_pkg::ST_FULL;
      end else begin
        status_r <= rmsa_pkg::ST_OK;
      end
    end
    if (state_r == S_STATS && count_r == rmsa_pkg::COUNT_BITS'(1)) begin
      // single sample: mean is the sample itself, no spread
      mean_r <= sum_r[rmsa_pkg::SAMPLE_BITS-1:0];
      sd_r   <= '0;
    end
    if (mean_done) begin
      mean_r <= sum_r[rmsa_pkg::SUM_W-1] ? rmsa_pkg::SAMPLE_BITS'(-mean_mag) : mean_mag;
    end
    if (state_r == S_NQ && mul_done) begin
      nq_r <= mul_prod;
    end
    if (state_r == S_SS && mul_done) begin
      diff_r <= nq_r - mul_prod;
    end
    if (sqrt_done) begin
      sd_r <= sqrt_root;
    end
    if (state_r == S_FIN && out_free) begin
      out_sample_count_r  <= rmsa_pkg::CNT_W'(count_r);
      out_mean_value_r    <= rmsa_pkg::VAL_W'(mean_r);
      out_std_deviation_r <= rmsa_pkg::VAL_W'(sd_r);
      out_last_value_r    <= rmsa_pkg::VAL_W'(last_r);
      out_status_code_r   <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_count  = out_sample_count_r;
  assign out_mean_value    = out_mean_value_r;
  assign out_std_deviation = out_std_deviation_r;
  assign out_last_value    = out_last_value_r;
  assign out_status_code   = out_status_code_r;

`ifndef SYNTH
  a_mul_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_SQR || state_r == S_NQ || state_r == S_SS || state_r == S_NN))
    else $error("multiplier result outside a multiply phase");

  // mean divide must land while the variance chain is still running
  a_mean_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mean_done |-> !(state_r == S_IDLE || state_r == S_FIN || state_r == S_SQR ||
                    state_r == S_STATS))
    else $error("mean divider finished outside the variance chain");

  a_var_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    var_done |-> state_r == S_DIV)
    else $error("variance divider result outside divide phase");

  a_sqrt_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == S_SQRT)
    else $error("square root result outside root phase");

  a_sd_small_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sample_count_r < rmsa_pkg::CNT_W'(2)) |-> out_std_deviation_r == '0)
    else $error("nonzero deviation with fewer than two samples");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_code_r == rmsa_pkg::ST_EMPTY) |->
      (out_sample_count_r == '0 && out_mean_value_r == '0))
    else $error("empty status with nonzero statistics");
`endif

endmodule

`default_nettype wire

// File: hdl/rmsa_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on rmsa_pkg for operand and product widths.
`default_nettype none

module rmsa_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rmsa_pkg::MA_W-1:0]         mcand,
  input  logic [rmsa_pkg::MB_W-1:0]         mplier,   // MSB-aligned
  input  logic [rmsa_pkg::MSTEP_W-1:0]      steps,
  output logic                              done,
  output logic [rmsa_pkg::PROD_W-1:0]       prod
);

  logic                           busy_r;
  logic                           done_r;
  logic [rmsa_pkg::MSTEP_W-1:0]   cnt_r;
  logic [rmsa_pkg::MA_W-1:0]      a_r;
  logic [rmsa_pkg::MB_W-1:0]      b_r;
  logic [rmsa_pkg::PROD_W-1:0]    acc_r;
  logic [rmsa_pkg::PROD_W-1:0]    acc_nxt;

  always_comb begin
    acc_nxt = {acc_r[rmsa_pkg::PROD_W-2:0], 1'b0}
            + (b_r[rmsa_pkg::MB_W-1] ? rmsa_pkg::PROD_W'(a_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == rmsa_pkg::MSTEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mcand;
      b_r   <= mplier;
      acc_r <= '0;
      cnt_r <= steps;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[rmsa_pkg::MB_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// File: hdl/rmsa_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on rmsa_pkg; the dividend comes in MSB-aligned, the quotient builds up in its place.
`default_nettype none

module rmsa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rmsa_pkg::PROD_W-1:0]       dividend,
  input  logic [rmsa_pkg::DIV_W-1:0]        divisor,
  input  logic [rmsa_pkg::DSTEP_W-1:0]      steps,
  output logic                              done,
  output logic [rmsa_pkg::PROD_W-1:0]       quot
);

  logic                           busy_r;
  logic                           done_r;
  logic [rmsa_pkg::DSTEP_W-1:0]   cnt_r;
  logic [rmsa_pkg::PROD_W-1:0]    dvd_r;
  logic [rmsa_pkg::DIV_W-1:0]     dsr_r;
  logic [rmsa_pkg::DIV_W-1:0]     rem_r;
  logic [rmsa_pkg::DIV_W:0]       trial;
  logic [rmsa_pkg::DIV_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial = {rem_r, dvd_r[rmsa_pkg::PROD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == rmsa_pkg::DSTEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= steps;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so the top bit drops cleanly
      rem_r <= ge ? diff[rmsa_pkg::DIV_W-1:0] : trial[rmsa_pkg::DIV_W-1:0];
      dvd_r <= {dvd_r[rmsa_pkg::PROD_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

`default_nettype wire

// File: hdl/rmsa_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on rmsa_pkg for the radicand and root widths.
`default_nettype none

module rmsa_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rmsa_pkg::VAR_W-1:0]        rad,
  output logic                              done,
  output logic [rmsa_pkg::ROOT_W-1:0]       root
);

  logic                           busy_r;
  logic                           done_r;
  logic [rmsa_pkg::RSTEP_W-1:0]   cnt_r;
  logic [rmsa_pkg::VAR_W-1:0]     rad_r;
  logic [rmsa_pkg::ROOT_W:0]      rem_r;
  logic [rmsa_pkg::ROOT_W-1:0]    root_r;
  logic [rmsa_pkg::ROOT_W+1:0]    trial_rem;
  logic [rmsa_pkg::ROOT_W+1:0]    trial;
  logic [rmsa_pkg::ROOT_W+1:0]    diff;
  logic                           ge;

  always_comb begin
    trial_rem = {rem_r[rmsa_pkg::ROOT_W-1:0], rad_r[rmsa_pkg::VAR_W-1 -: 2]};
    trial     = {root_r, 2'b01};
    diff      = trial_rem - trial;
    ge        = trial_rem >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == rmsa_pkg::RSTEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= rmsa_pkg::RSTEP_W'(rmsa_pkg::ROOT_W);
    end else if (busy_r) begin
      // remainder never exceeds twice the partial root
      rem_r  <= ge ? diff[rmsa_pkg::ROOT_W:0] : trial_rem[rmsa_pkg::ROOT_W:0];
      root_r <= {root_r[rmsa_pkg::ROOT_W-2:0], ge};
      rad_r  <= {rad_r[rmsa_pkg::VAR_W-3:0], 2'b00};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: tb/rmsa_stats_checker.sv
`timescale 1ns / 1ps
// Scoreboard for running_mean_stddev_accumulator_top: watches the input and result channels
// and keeps its own count, sum, sum of squares and last sample. Depends on rmsa_pkg.

module rmsa_stats_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [rmsa_pkg::VAL_W-1:0] in_sample_value,
  input  logic                              in_clear_request,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rmsa_pkg::CNT_W-1:0]        out_sample_count,
  input  logic signed [rmsa_pkg::VAL_W-1:0] out_mean_value,
  input  logic [rmsa_pkg::VAL_W-1:0]        out_std_deviation,
  input  logic signed [rmsa_pkg::VAL_W-1:0] out_last_value,
  input  logic [rmsa_pkg::STAT_W-1:0]       out_status_code,
  output int                                mismatch_count,
  output int                                pending_words,
  output int                                results_checked,
  output int                                peak_count
);

  typedef struct {
    logic [rmsa_pkg::CNT_W-1:0]        count;
    logic signed [rmsa_pkg::VAL_W-1:0] mean;
    logic [rmsa_pkg::VAL_W-1:0]        stddev;
    logic signed [rmsa_pkg::VAL_W-1:0] last;
    rmsa_pkg::status_t                 status;
  } stats_word_t;

  stats_word_t expected_stats_q[$];

  logic [rmsa_pkg::CNT_W-1:0]        n_acc;
  longint                            sum_acc;
  logic [63:0]                       sumsq_acc;
  logic signed [rmsa_pkg::VAL_W-1:0] last_acc;

  // floor(sqrt(floor((n*Q - S*S) / (n*(n-1))))), exact in 128 bits
  function automatic logic [rmsa_pkg::VAL_W-1:0] sample_stddev(
      logic [rmsa_pkg::CNT_W-1:0] n, longint s, logic [63:0] q);
    logic [127:0] spread;
    logic [127:0] root;
    logic [127:0] trial;
    logic [63:0]  mag;
    if (n < 2) return '0;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    spread = 128'(n) * 128'(q) - 128'(mag) * 128'(mag);
    spread = spread / (128'(n) * (128'(n) - 128'd1));
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= spread) root = trial;
    end
    return root[rmsa_pkg::VAL_W-1:0];
  endfunction

  function automatic stats_word_t predict_stats(logic signed [rmsa_pkg::VAL_W-1:0] value,
                                                logic clr);
    stats_word_t w;
    longint v;
    v = longint'(value);
    w.status = rmsa_pkg::ST_OK;
    if (clr) begin
      n_acc = '0;
      sum_acc = 0;
      sumsq_acc = '0;
      last_acc = '0;
    end else if (n_acc == rmsa_pkg::COUNT_FULL) begin
      w.status = rmsa_pkg::ST_FULL;
    end else begin
      n_acc = n_acc + 1'b1;
      sum_acc += v;
      sumsq_acc += 64'(v * v);
      last_acc = value;
    end
    if (n_acc == 0) begin
      w.count = '0;
      w.mean = '0;
      w.stddev = '0;
      w.last = '0;
      w.status = rmsa_pkg::ST_EMPTY;
    end else begin
      w.count = n_acc;
      w.mean = rmsa_pkg::VAL_W'(sum_acc / longint'(n_acc));
      w.stddev = sample_stddev(n_acc, sum_acc, sumsq_acc);
      w.last = last_acc;
    end
    return w;
  endfunction

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    stats_word_t w;
    if (!rst_n) begin
      n_acc = '0;
      sum_acc = 0;
      sumsq_acc = '0;
      last_acc = '0;
      expected_stats_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stats_q.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result word with none expected, actual count %0d status %0d",
                   $time, out_sample_count, out_status_code);
        end else begin
          w = expected_stats_q.pop_front();
          compare_field("sample_count", longint'(w.count), longint'(out_sample_count));
          compare_field("mean_value", longint'(w.mean), longint'(out_mean_value));
          compare_field("std_deviation", longint'(w.stddev), longint'(out_std_deviation));
          compare_field("last_value", longint'(w.last), longint'(out_last_value));
          compare_field("status_code", longint'(w.status), longint'(out_status_code));
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_stats_q.push_back(predict_stats(in_sample_value, in_clear_request));
        if (int'(n_acc) > peak_count) peak_count = int'(n_acc);
      end
    end
    pending_words = expected_stats_q.size();
  end

endmodule

// File: tb/running_mean_stddev_accumulator_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the running mean / std-dev accumulator: clock, reset, sample and clear
// words with random idling and back-pressure, and the verdict.
// Depends on rmsa_pkg, running_mean_stddev_accumulator_top and rmsa_stats_checker.

module running_mean_stddev_accumulator_top_test;

  localparam int RANDOM_WORDS  = 1300;
  localparam int HOLD_CYCLES   = 700;
  localparam int SETTLE_CYCLES = 400;

  localparam logic signed [rmsa_pkg::VAL_W-1:0] VAL_MAX =
    {1'b0, {(rmsa_pkg::VAL_W-1){1'b1}}};
  localparam logic signed [rmsa_pkg::VAL_W-1:0] VAL_MIN =
    {1'b1, {(rmsa_pkg::VAL_W-1){1'b0}}};

  typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_EDGE, SPREAD_CLUSTER} spread_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [rmsa_pkg::VAL_W-1:0] in_sample_value;
  logic                              in_clear_request;
  logic                              out_valid;
  logic                              out_ready;
  logic [rmsa_pkg::CNT_W-1:0]        out_sample_count;
  logic signed [rmsa_pkg::VAL_W-1:0] out_mean_value;
  logic [rmsa_pkg::VAL_W-1:0]        out_std_deviation;
  logic signed [rmsa_pkg::VAL_W-1:0] out_last_value;
  logic [rmsa_pkg::STAT_W-1:0]       out_status_code;

  int mismatch_count, pending_words, results_checked, peak_count;
  int words_sent, clears_sent, hold_left;
  bit steady;

  running_mean_stddev_accumulator_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_clear_request  (in_clear_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_count  (out_sample_count),
    .out_mean_value    (out_mean_value),
    .out_std_deviation (out_std_deviation),
    .out_last_value    (out_last_value),
    .out_status_code   (out_status_code)
  );

  rmsa_stats_checker stats_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_clear_request  (in_clear_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_count  (out_sample_count),
    .out_mean_value    (out_mean_value),
    .out_std_deviation (out_std_deviation),
    .out_last_value    (out_last_value),
    .out_status_code   (out_status_code),
    .mismatch_count    (mismatch_count),
    .pending_words     (pending_words),
    .results_checked   (results_checked),
    .peak_count        (peak_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [rmsa_pkg::VAL_W-1:0] random_sample(
      spread_t style, logic signed [rmsa_pkg::VAL_W-1:0] base);
    logic signed [rmsa_pkg::VAL_W-1:0] pick;
    case (style)
      SPREAD_SMALL:   pick = rmsa_pkg::VAL_W'(int'($urandom_range(0, 510)) - 255);
      SPREAD_CLUSTER: pick = base + rmsa_pkg::VAL_W'(int'($urandom_range(0, 6)) - 3);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0:       pick = VAL_MIN;
          1:       pick = VAL_MAX;
          2:       pick = '1;
          3:       pick = '0;
          default: pick = rmsa_pkg::VAL_W'(1);
        endcase
      end
      default:        pick = rmsa_pkg::VAL_W'($urandom());
    endcase
    return pick;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_word(logic signed [rmsa_pkg::VAL_W-1:0] value, logic clr);
    if (!steady && $urandom_range(0, 99) < 18) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 6))
        @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample_value = value;
    in_clear_request = clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (clr) clears_sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off counted here
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = steady || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    int first_random;
    int run_len;
    spread_t style;
    logic signed [rmsa_pkg::VAL_W-1:0] base;
    bit hold_done, pause_done, steady_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    in_clear_request = 1'b0;
    steady = 1'b0;
    hold_left = 0;
    words_sent = 0;
    clears_sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    steady_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty after reset, clear with a stray sample value ignored
    offer_word('0, 1'b1);
    offer_word(VAL_MAX, 1'b1);
    // single sample, then both extremes (mean truncates toward zero)
    offer_word(VAL_MAX, 1'b0);
    offer_word(VAL_MIN, 1'b0);
    offer_word(VAL_MIN, 1'b0);
    offer_word(VAL_MAX, 1'b0);
    offer_word('0, 1'b1);
    offer_word(-24'sd1, 1'b0);
    offer_word(24'sd0, 1'b0);
    offer_word(-24'sd2, 1'b0);
    offer_word(24'sd1, 1'b0);
    offer_word(24'sd5, 1'b1);
    // zero variance, then one step of 256 either way
    offer_word(24'sd0, 1'b0);
    offer_word(24'sd0, 1'b0);
    offer_word(24'sd256, 1'b0);
    offer_word(-24'sd256, 1'b0);
    offer_word(24'sh555555, 1'b0);
    offer_word(24'shAAAAAA, 1'b0);
    offer_word(VAL_MIN, 1'b1);
    offer_word(24'sd1, 1'b0);
    offer_word(24'sd2, 1'b0);
    offer_word(24'sd3, 1'b0);
    // full count needs 65535 samples, far past this run;
    // the scoreboard still models it
    drain();

    first_random = words_sent;
    while (words_sent - first_random < RANDOM_WORDS) begin
      offer_word(random_sample(SPREAD_FULL, '0), 1'b1);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      style = spread_t'($urandom_range(0, 3));
      base = random_sample(SPREAD_FULL, '0);
      repeat (run_len) begin
        if (words_sent - first_random >= RANDOM_WORDS) break;
        if (!hold_done && words_sent - first_random >= 300) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (!steady_done && words_sent - first_random >= 500) begin
          steady_done = 1'b1;
          steady = 1'b1;
        end
        if (steady && words_sent - first_random >= 700) steady = 1'b0;
        if (!pause_done && words_sent - first_random >= 900) begin
          pause_done = 1'b1;
          drain();
        end
        // stray clears break a run now and then
        offer_word(random_sample(style, base), $urandom_range(0, 49) == 0);
      end
    end

    in_valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d words (%0d clears), %0d results checked, peak count %0d.",
             words_sent, clears_sent, results_checked, peak_count);
    $display("Included a long result hold-off, a drain pause and a stall-free stretch.");
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the ~1330 words of the run plus the longest sender idles
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: running_mean_stddev_accumulator_top.f
hdl/rmsa_pkg.sv
hdl/rmsa_mul.sv
hdl/rmsa_div.sv
hdl/rmsa_sqrt.sv
hdl/running_mean_stddev_accumulator_top.sv
tb/rmsa_stats_checker.sv
tb/running_mean_stddev_accumulator_top_test.sv
